// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros. Every use needs a clock i_clk and a reset i_rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/lzte_pkg.sv =====
// ----------------------------------------------------------------------------
// lzte_pkg
// Types and codes shared by the token expander controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lzte_pkg;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD     = 2'd1,
        ST_IGNORED = 2'd2
    } t_status;

    typedef enum logic {
        OP_LITERAL = 1'b0,
        OP_MATCH   = 1'b1
    } t_opcode;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    lit;
        logic    stop;
        logic    wr;
        logic    emit;
        logic    last;
        t_status status;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic skip;
        logic bad;
        logic is_lit;
        logic zero_len;
        logic pack_end;
        logic rem_zero;
        logic slot_free;
    } t_stat;

endpackage

// ===== rtl/lzte_ctrl.sv =====
// ----------------------------------------------------------------------------
// lzte_ctrl
// Sequencer for the token expander: decides each token and steps the copy.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lzte_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  lzte_pkg::t_stat i_stat,
    output lzte_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_RD,
        S_WR,
        S_EMIT
    } t_state;

    t_state            r_state, n_state;
    lzte_pkg::t_status r_status, n_status;
    logic              r_copy, n_copy;

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        n_copy   = r_copy;
        o_cmd    = '0;
        o_cmd.status = r_status;
        o_cmd.last   = !r_copy || i_stat.rem_zero;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_copy   = 1'b0;
                n_status = lzte_pkg::ST_OK;
                n_state  = S_EMIT;
                if (i_stat.skip) begin
                    n_status = lzte_pkg::ST_IGNORED;
                end else if (i_stat.is_lit) begin
                    o_cmd.lit = 1'b1;
                end else if (i_stat.bad) begin
                    o_cmd.stop = 1'b1;
                    n_status   = lzte_pkg::ST_BAD;
                end else if (!i_stat.zero_len) begin
                    n_copy  = 1'b1;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_WR;
            end
            S_WR: begin
                o_cmd.wr = 1'b1;
                n_state  = i_stat.pack_end ? S_EMIT : S_RD;
            end
            S_EMIT: begin
                if (i_stat.slot_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = (!r_copy || i_stat.rem_zero) ? S_IDLE : S_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= lzte_pkg::ST_OK;
            r_copy   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_copy   <= n_copy;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    `ASSERT_SAME(a_wr_after_rd, r_state == S_WR, $past(r_state) == S_RD)
    `ASSERT_SAME(a_emit_has_slot, o_cmd.emit, i_stat.slot_free)
    `ASSERT_SAME(a_load_when_ready, o_cmd.load, o_ready)

endmodule

// ===== rtl/lzte_datapath.sv =====
// ----------------------------------------------------------------------------
// lzte_datapath
// History memory, counters, byte packing and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lzte_datapath #(
    parameter int HISTORY_DEPTH = 32768,
    parameter int OUT_LANES     = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [31:0]     i_cfg_wdata,
    input  logic            i_opcode,
    input  logic [7:0]      i_literal_byte,
    input  logic [15:0]     i_match_distance,
    input  logic [7:0]      i_match_length,
    input  lzte_pkg::t_cmd  i_cmd,
    output lzte_pkg::t_stat o_stat,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [63:0]     o_data_bytes,
    output logic [3:0]      o_byte_count,
    output logic            o_last,
    output logic [1:0]      o_status,
    output logic            o_done_res
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int CW = 18;

    logic [7:0]    mem [HISTORY_DEPTH];
    logic [7:0]    r_rdata;
    logic          r_op;
    logic [7:0]    r_lit;
    logic [15:0]   r_dist;
    logic [7:0]    r_rem;
    logic [AW-1:0] r_widx;
    logic [31:0]   r_prod;
    logic          r_stop;
    logic [31:0]   r_exp;
    logic [63:0]   r_word;
    logic [3:0]    r_lane;

    logic [CW-1:0] src_sum;
    logic [AW-1:0] src_addr;
    logic          mem_we;
    logic [7:0]    mem_wdata;
    logic [31:0]   prod_inc;
    logic [AW-1:0] widx_inc;

    always_comb begin
        src_sum = CW'(r_widx) + CW'(HISTORY_DEPTH) - CW'(r_dist);
        if (src_sum >= CW'(HISTORY_DEPTH)) begin
            src_sum = src_sum - CW'(HISTORY_DEPTH);
        end
        src_addr = src_sum[AW-1:0];
    end

    assign mem_we    = i_cmd.lit || i_cmd.wr;
    assign mem_wdata = i_cmd.lit ? r_lit : r_rdata;
    assign prod_inc  = (r_prod == 32'hFFFF_FFFF) ? r_prod : r_prod + 32'd1;
    assign widx_inc  = (r_widx == AW'(HISTORY_DEPTH - 1)) ? '0 : r_widx + AW'(1);

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[src_addr];
        if (mem_we) begin
            mem[r_widx] <= mem_wdata;
        end
    end

    assign o_stat.skip      = r_stop || (r_prod >= r_exp);
    assign o_stat.bad       = (r_dist == 16'd0) || (32'(r_dist) > r_prod)
                              || (32'(r_dist) > 32'(HISTORY_DEPTH));
    assign o_stat.is_lit    = (r_op == lzte_pkg::OP_LITERAL);
    assign o_stat.zero_len  = (r_rem == 8'd0);
    assign o_stat.pack_end  = (r_lane + 4'd1 == 4'(OUT_LANES)) || (r_rem == 8'd1);
    assign o_stat.rem_zero  = (r_rem == 8'd0);
    assign o_stat.slot_free = !o_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_widx  <= '0;
            r_prod  <= '0;
            r_stop  <= 1'b0;
            r_exp   <= '0;
            r_word  <= '0;
            r_lane  <= '0;
            o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_exp <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_op   <= i_opcode;
                r_lit  <= i_literal_byte;
                r_dist <= i_match_distance;
                r_rem  <= i_match_length;
            end
            if (i_cmd.stop) begin
                r_stop <= 1'b1;
            end
            if (mem_we) begin
                r_widx <= widx_inc;
                r_prod <= prod_inc;
                r_word[8*r_lane[2:0] +: 8] <= mem_wdata;
                r_lane <= r_lane + 4'd1;
            end
            if (i_cmd.wr) begin
                r_rem <= r_rem - 8'd1;
            end
            if (i_cmd.emit) begin
                o_valid      <= 1'b1;
                o_data_bytes <= r_word;
                o_byte_count <= r_lane;
                o_last       <= i_cmd.last;
                o_status     <= i_cmd.status;
                o_done_res   <= (r_prod >= r_exp);
                r_word       <= '0;
                r_lane       <= '0;
            end else if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    `ASSERT_NEXT(a_stop_sticky, r_stop, r_stop)
    `ASSERT_NEXT(a_prod_monotonic, 1'b1, r_prod >= $past(r_prod))
    `ASSERT_SAME(a_lane_bound, o_valid, o_byte_count <= 4'(OUT_LANES))

endmodule

// ===== rtl/lz77_token_expander.sv =====
// ----------------------------------------------------------------------------
// lz77_token_expander
// Expands LZ77 literal and match tokens into packed output byte words.
// ----------------------------------------------------------------------------
//  Channel   Handshake                Payload
//  token     i_valid / o_ready        i_opcode, i_literal_byte, i_match_distance,
//                                     i_match_length
//  result    o_valid / i_ready        o_data_bytes, o_byte_count, o_last,
//                                     o_status, o_done_res
//  config    i_cfg_we                 i_cfg_wdata (expected length)
//
// A token is taken in the idle state and decided in the next cycle. A literal,
// a bad distance, an ignored token or an empty match then gives its one result
// from the emit state, which waits for a free output slot. A match copies one
// byte per pass through the read and write states, since the history memory
// read is registered, and passes through the emit state once per result word.
// Reset is synchronous and active low; the history memory is not cleared.
// A result word that is not taken stalls the next emit step until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lz77_token_expander #(
    parameter int HISTORY_DEPTH = 32768,
    parameter int OUT_LANES     = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_opcode,
    input  logic [7:0]  i_literal_byte,
    input  logic [15:0] i_match_distance,
    input  logic [7:0]  i_match_length,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_data_bytes,
    output logic [3:0]  o_byte_count,
    output logic        o_last,
    output logic [1:0]  o_status,
    output logic        o_done_res
);

    // The controller and the datapath talk only through these two groups.
    lzte_pkg::t_cmd  cmd;
    lzte_pkg::t_stat stat;

    lzte_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    lzte_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .OUT_LANES     (OUT_LANES)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_opcode         (i_opcode),
        .i_literal_byte   (i_literal_byte),
        .i_match_distance (i_match_distance),
        .i_match_length   (i_match_length),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_data_bytes     (o_data_bytes),
        .o_byte_count     (o_byte_count),
        .o_last           (o_last),
        .o_status         (o_status),
        .o_done_res       (o_done_res)
    );

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LZ77 token expander. The bench drives literal
// and match tokens through the token channel and predicts every result word
// with its own model of the history ring and byte counter. It compares each
// result transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int RING_DEPTH  = 32768;
    localparam int LANES       = 8;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int IDLE_PCT    = 13;

    typedef struct {
        lzte_pkg::t_opcode op;
        logic [7:0]        lit;
        logic [15:0]       distance;
        logic [7:0]        len;
    } t_token;

    typedef struct {
        logic [63:0]       data;
        logic [3:0]        count;
        logic              last;
        lzte_pkg::t_status status;
        logic              done;
    } t_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_wdata = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_opcode = 1'b0;
    logic [7:0]  i_literal_byte = '0;
    logic [15:0] i_match_distance = '0;
    logic [7:0]  i_match_length = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [63:0] o_data_bytes;
    logic [3:0]  o_byte_count;
    logic        o_last;
    logic [1:0]  o_status;
    logic        o_done_res;

    // Tokens waiting to be driven, and result words still owed by the block.
    t_token pending_tokens[$];
    t_word  owed_words[$];

    // Predictor state: a private copy of the ring, counters and register.
    logic [7:0]  ring[RING_DEPTH];
    logic [14:0] wr_ptr = '0;
    logic [31:0] out_total = '0;
    logic        halted = 1'b0;
    logic [31:0] target_len = '0;

    // The generator tracks how many bytes the stream holds so that it only
    // issues distances that reach written history.
    int unsigned stream_bytes = 0;
    int unsigned queued_count = 0;
    int unsigned taken_count = 0;
    bit          calm = 1'b0;
    int          fail_count = 0;
    int unsigned cycle_count = 0;

    lz77_token_expander uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_opcode         (i_opcode),
        .i_literal_byte   (i_literal_byte),
        .i_match_distance (i_match_distance),
        .i_match_length   (i_match_length),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_data_bytes     (o_data_bytes),
        .o_byte_count     (o_byte_count),
        .o_last           (o_last),
        .o_status         (o_status),
        .o_done_res       (o_done_res)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Appends one byte to the predicted stream; the counter saturates.
    function automatic void store_byte(input logic [7:0] b);
        ring[wr_ptr] = b;
        wr_ptr = wr_ptr + 1'b1;
        if (out_total != 32'hFFFF_FFFF) begin
            out_total = out_total + 32'd1;
        end
    endfunction

    function automatic void owe(input logic [63:0] data, input logic [3:0] count,
                                input logic last, input lzte_pkg::t_status status);
        t_word w;
        w.data = data;
        w.count = count;
        w.last = last;
        w.status = status;
        w.done = (out_total >= target_len);
        owed_words.insert(owed_words.size(), w);
    endfunction

    // Appends a token to the driver's queue.
    function automatic void add_token(input t_token t);
        pending_tokens.insert(pending_tokens.size(), t);
        queued_count++;
    endfunction

    // Works out the result words that one accepted token produces.
    function automatic void expand_token(input t_token t);
        int unsigned copied;
        int unsigned lane;
        logic [63:0] word;
        logic [7:0]  b;
        logic [14:0] src;
        copied = 0;
        if (halted || out_total >= target_len) begin
            owe('0, 4'd0, 1'b1, lzte_pkg::ST_IGNORED);
        end else if (t.op == lzte_pkg::OP_LITERAL) begin
            store_byte(t.lit);
            owe({56'd0, t.lit}, 4'd1, 1'b1, lzte_pkg::ST_OK);
        end else if (t.distance == 0 || t.distance > out_total || t.distance > RING_DEPTH) begin
            halted = 1'b1;
            owe('0, 4'd0, 1'b1, lzte_pkg::ST_BAD);
        end else if (t.len == 0) begin
            owe('0, 4'd0, 1'b1, lzte_pkg::ST_OK);
        end else begin
            while (copied < t.len) begin
                word = '0;
                lane = 0;
                while (lane < LANES && copied < t.len) begin
                    // The ring wraps naturally in the 15-bit pointer.
                    src = wr_ptr - t.distance[14:0];
                    b = ring[src];
                    store_byte(b);
                    word[8*lane +: 8] = b;
                    lane++;
                    copied++;
                end
                owe(word, lane[3:0], copied >= t.len, lzte_pkg::ST_OK);
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        fail_count++;
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
                 want);
    endtask

    // Token driver. A transaction completes on valid and ready; the next token
    // is loaded in the same step, so valid is assigned at most once per edge.
    always @(posedge i_clk) begin
        t_token t;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) begin
                t.op = lzte_pkg::t_opcode'(i_opcode);
                t.lit = i_literal_byte;
                t.distance = i_match_distance;
                t.len = i_match_length;
                expand_token(t);
                taken_count++;
            end
            if (pending_tokens.size() > 0 &&
                (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                t = pending_tokens.pop_front();
                i_valid <= 1'b1;
                i_opcode <= t.op;
                i_literal_byte <= t.lit;
                i_match_distance <= t.distance;
                i_match_length <= t.len;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result monitor. Ready is redrawn every cycle; the check uses the values
    // present just before the edge.
    always @(posedge i_clk) begin
        t_word w;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            if (o_valid && i_ready) begin
                if (owed_words.size() == 0) begin
                    report_mismatch("unexpected result", o_data_bytes, 64'd0);
                end else begin
                    w = owed_words.pop_front();
                    if (o_data_bytes !== w.data)
                        report_mismatch("data_bytes", o_data_bytes, w.data);
                    if (o_byte_count !== w.count)
                        report_mismatch("byte_count", 64'(o_byte_count), 64'(w.count));
                    if (o_last !== w.last)
                        report_mismatch("last", 64'(o_last), 64'(w.last));
                    if (o_status !== w.status)
                        report_mismatch("status", 64'(o_status), 64'(w.status));
                    if (o_done_res !== w.done)
                        report_mismatch("done_res", 64'(o_done_res), 64'(w.done));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic queue_literal(input logic [7:0] b);
        t_token t;
        t.op = lzte_pkg::OP_LITERAL;
        t.lit = b;
        t.distance = 16'($urandom);
        t.len = 8'($urandom);
        add_token(t);
        stream_bytes++;
    endtask

    // Queues a match; a good distance grows the stream by its length.
    task automatic queue_match(input logic [15:0] d, input logic [7:0] l);
        t_token t;
        t.op = lzte_pkg::OP_MATCH;
        t.lit = 8'($urandom);
        t.distance = d;
        t.len = l;
        add_token(t);
        stream_bytes += l;
    endtask

    function automatic logic [15:0] legal_dist();
        int unsigned reach;
        reach = (stream_bytes < RING_DEPTH) ? stream_bytes : RING_DEPTH;
        return 16'($urandom_range(1, reach));
    endfunction

    // Waits until every queued token is accepted and every result word is
    // back, then lets the block settle before anything else happens.
    task automatic wait_quiet();
        while (taken_count != queued_count || owed_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_target(input logic [31:0] value);
        wait_quiet();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        target_len = value;
    endtask

    initial begin
        int pick;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A zero target is done from reset, so these tokens are ignored and
        // add nothing to the stream.
        write_target(32'd0);
        add_token('{lzte_pkg::OP_LITERAL, 8'hA5, 16'd0, 8'd0});
        add_token('{lzte_pkg::OP_MATCH, 8'h00, 16'd1, 8'd4});

        // Directed tokens: extreme bytes, an empty match, overlapped copies
        // and word boundaries.
        write_target(32'hFFFF_FFFF);
        queue_literal(8'h00);
        queue_literal(8'hFF);
        queue_match(16'd1, 8'd0);
        queue_match(16'd1, 8'd1);
        queue_literal(8'h5A);
        queue_match(16'd2, 8'd8);
        queue_match(16'd3, 8'd9);
        queue_match(16'd1, 8'd255);
        queue_literal(8'h3C);
        queue_match(16'd7, 8'd16);
        queue_match(16'd40, 8'd17);
        queue_match(16'(stream_bytes), 8'd7);

        // Reach the target partway through a match: the copy finishes in full
        // and the following tokens are ignored until the target is raised.
        wait_quiet();
        write_target(out_total + 32'd5);
        queue_match(16'd4, 8'd20);
        add_token('{lzte_pkg::OP_LITERAL, 8'h11, 16'd0, 8'd0});
        add_token('{lzte_pkg::OP_MATCH, 8'h00, 16'd1, 8'd3});
        wait_quiet();
        write_target(out_total + 32'd3);
        queue_literal(8'h81);
        queue_literal(8'h42);
        queue_literal(8'h24);
        write_target(32'hFFFF_FFFF);

        // Random tokens, the first stretch with both sides always willing.
        calm = 1'b1;
        for (int n = 0; n < 160; n++) begin
            if (n == 60) begin
                while (pending_tokens.size() != 0) begin
                    @(posedge i_clk);
                end
                calm = 1'b0;
            end
            if ($urandom_range(0, 99) < 40) begin
                queue_literal(8'($urandom));
            end else if ($urandom_range(0, 9) == 0) begin
                queue_match(legal_dist(), 8'($urandom_range(0, 255)));
            end else begin
                queue_match(legal_dist(), 8'($urandom_range(0, 24)));
            end
        end

        // Fill the ring past its depth to reach the farthest distances.
        while (stream_bytes <= RING_DEPTH + 300) begin
            queue_match(legal_dist(), 8'd255);
        end
        queue_match(16'd32768, 8'd12);
        queue_match(16'd32767, 8'd9);
        queue_literal(8'($urandom));

        // One bad distance stops the block for good, so it comes last.
        pick = $urandom_range(0, 2);
        case (pick)
            0: add_token('{lzte_pkg::OP_MATCH, 8'h00, 16'd0, 8'd5});
            1: add_token('{lzte_pkg::OP_MATCH, 8'h00, 16'hFFFF, 8'd5});
            default: add_token('{lzte_pkg::OP_MATCH, 8'h00, 16'd32769, 8'd5});
        endcase
        add_token('{lzte_pkg::OP_LITERAL, 8'h77, 16'd0, 8'd0});
        add_token('{lzte_pkg::OP_MATCH, 8'h00, 16'd1, 8'd2});

        wait_quiet();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

// ===== lz77_token_expander.f =====
+incdir+rtl
rtl/lzte_pkg.sv
rtl/lzte_ctrl.sv
rtl/lzte_datapath.sv
rtl/lz77_token_expander.sv
bench/tb_top.sv
